### hdl/radar_lag_product_accumulator_core_defines.svh
// assertion macros used by the checker
`ifndef RADAR_LAG_PRODUCT_ACCUMULATOR_CORE_DEFINES_SVH
`define RADAR_LAG_PRODUCT_ACCUMULATOR_CORE_DEFINES_SVH

// same-cycle implication
`define RLPA_ASSERT_IMPLY(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("rlpa same-cycle check failed");

// next-cycle implication
`define RLPA_ASSERT_NEXT(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("rlpa next-cycle check failed");

`endif

### hdl/rlpa_pkg.sv
package rlpa_pkg;

  localparam int unsigned SAMPLE_DEPTH = 16384;
  localparam int unsigned SAMPLE_AW    = $clog2(SAMPLE_DEPTH);
  localparam int unsigned MAX_RANGES   = 128;
  localparam int unsigned MAX_LAGS     = 32;
  localparam int unsigned ACC_DEPTH    = MAX_RANGES * MAX_LAGS;
  localparam int unsigned ACC_AW       = $clog2(ACC_DEPTH);
  localparam int unsigned LAG_AW       = $clog2(MAX_LAGS);
  localparam int unsigned RANGE_W      = $clog2(MAX_RANGES);
  localparam int unsigned CFG_IW       = 3;
  localparam int unsigned CFG_DW       = 14;

  typedef enum logic [2:0] {
    ACT_LOAD_SAMPLE = 3'd0,
    ACT_LOAD_LAG    = 3'd1,
    ACT_RUN         = 3'd2,
    ACT_CLEAR       = 3'd3,
    ACT_READ        = 3'd4
  } action_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_NUM_RANGES   = 3'd0,
    CFG_NUM_LAGS     = 3'd1,
    CFG_SAMPLE_UNIT  = 3'd2,
    CFG_RANGE_STRIDE = 3'd3,
    CFG_XCF_MODE     = 3'd4,
    CFG_XCF_OFFSET   = 3'd5,
    CFG_BAD_RANGE    = 3'd6,
    CFG_START_DELAY  = 3'd7
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_LAG,
    S_RD,
    S_MUL,
    S_SCL,
    S_ACC,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [13:0]        address;
    logic signed [15:0] sample_value;
    logic [7:0]         lag_first;
    logic [7:0]         lag_second;
    logic signed [23:0] dc_real_main;
    logic signed [23:0] dc_imag_main;
    logic signed [23:0] dc_real_second;
    logic signed [23:0] dc_imag_second;
    logic [3:0]         real_offset;
    logic [3:0]         imag_offset;
    logic [16:0]        atten_recip;
  } in_t;

  typedef struct packed {
    logic signed [63:0] acf_real;
    logic signed [63:0] acf_imag;
    logic               done_res;
  } res_t;

  typedef struct packed {
    logic               capture;
    logic               clr_we;
    logic [ACC_AW-1:0]  clr_addr;
    logic               lag_step;
    logic [RANGE_W-1:0] rng;
    logic [LAG_AW-1:0]  lag;
    logic [ACC_AW-1:0]  idx;
    logic               rd_step;
    logic               mul_step;
    logic               scl_step;
    logic [2:0]         cnt;
    logic               acc_re;
    logic               acc_we;
    logic               res_valid;
    logic               res_run;
    logic               res_read;
  } cmd_t;

  typedef struct packed {
    logic [RANGE_W:0]  nr;
    logic [LAG_AW-1:0] nl;
    logic              rec_zero;
    logic [2:0]        in_action;
  } sts_t;

endpackage

### hdl/rlpa_ctrl.sv
module rlpa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  rlpa_pkg::sts_t  sts_i,
  output rlpa_pkg::cmd_t  cmd_o
);

  rlpa_pkg::state_e state_q, state_d;
  logic [2:0]                   cnt_q, cnt_d;
  logic [rlpa_pkg::ACC_AW-1:0]  clr_q, clr_d;
  logic [rlpa_pkg::ACC_AW-1:0]  idx_q, idx_d;
  logic [rlpa_pkg::RANGE_W-1:0] rng_q, rng_d;
  logic [rlpa_pkg::LAG_AW-1:0]  lag_q, lag_d;
  logic run_q, run_d, read_q, read_d, clritem_q, clritem_d;
  logic cnt_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rlpa_pkg::S_CLEAR;
      cnt_q     <= '0;
      clr_q     <= '0;
      idx_q     <= '0;
      rng_q     <= '0;
      lag_q     <= '0;
      run_q     <= 1'b0;
      read_q    <= 1'b0;
      clritem_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      clr_q     <= clr_d;
      idx_q     <= idx_d;
      rng_q     <= rng_d;
      lag_q     <= lag_d;
      run_q     <= run_d;
      read_q    <= read_d;
      clritem_q <= clritem_d;
    end
  end

  assign cnt_end = (cnt_q == 3'd4);
  assign busy    = (state_q != rlpa_pkg::S_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    clr_d     = clr_q;
    idx_d     = idx_q;
    rng_d     = rng_q;
    lag_d     = lag_q;
    run_d     = run_q;
    read_d    = read_q;
    clritem_d = clritem_q;
    cmd_o          = '0;
    cmd_o.clr_addr = clr_q;
    cmd_o.rng      = rng_q;
    cmd_o.lag      = lag_q;
    cmd_o.idx      = idx_q;
    cmd_o.cnt      = cnt_q;
    cmd_o.res_run  = run_q;
    cmd_o.res_read = read_q;
    case (state_q)
      rlpa_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          run_d     = 1'b0;
          read_d    = 1'b0;
          clritem_d = 1'b0;
          cnt_d     = '0;
          state_d   = rlpa_pkg::S_DONE;
          case (sts_i.in_action)
            rlpa_pkg::ACT_RUN: begin
              run_d = 1'b1;
              rng_d = '0;
              lag_d = '0;
              idx_d = '0;
              if (sts_i.nr != '0 && sts_i.nl != '0) begin
                state_d = rlpa_pkg::S_LAG;
              end
            end
            rlpa_pkg::ACT_CLEAR: begin
              clritem_d = 1'b1;
              clr_d     = '0;
              state_d   = rlpa_pkg::S_CLEAR;
            end
            rlpa_pkg::ACT_READ: begin
              read_d       = 1'b1;
              cmd_o.acc_re = 1'b1;
            end
            default: begin
              state_d = rlpa_pkg::S_DONE;
            end
          endcase
        end
      end
      rlpa_pkg::S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = clritem_q ? rlpa_pkg::S_DONE : rlpa_pkg::S_IDLE;
        end
      end
      rlpa_pkg::S_LAG: begin
        cmd_o.lag_step = 1'b1;
        cnt_d   = '0;
        state_d = rlpa_pkg::S_RD;
      end
      rlpa_pkg::S_RD: begin
        cmd_o.rd_step = 1'b1;
        cmd_o.acc_re  = (cnt_q == 3'd0);
        cnt_d = cnt_end ? 3'd0 : cnt_q + 3'd1;
        if (cnt_end) begin
          state_d = rlpa_pkg::S_MUL;
        end
      end
      rlpa_pkg::S_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = cnt_end ? 3'd0 : cnt_q + 3'd1;
        if (cnt_end) begin
          state_d = sts_i.rec_zero ? rlpa_pkg::S_ACC : rlpa_pkg::S_SCL;
        end
      end
      rlpa_pkg::S_SCL: begin
        cmd_o.scl_step = 1'b1;
        cnt_d = cnt_end ? 3'd0 : cnt_q + 3'd1;
        if (cnt_end) begin
          state_d = rlpa_pkg::S_ACC;
        end
      end
      rlpa_pkg::S_ACC: begin
        cmd_o.acc_we = 1'b1;
        idx_d = idx_q + 1'b1;
        state_d = rlpa_pkg::S_LAG;
        if (lag_q == sts_i.nl - 1'b1) begin
          lag_d = '0;
          rng_d = rng_q + 1'b1;
          if ({1'b0, rng_q} == sts_i.nr - 1'b1) begin
            state_d = rlpa_pkg::S_DONE;
          end
        end else begin
          lag_d = lag_q + 1'b1;
        end
      end
      rlpa_pkg::S_DONE: begin
        cmd_o.res_valid = 1'b1;
        state_d = rlpa_pkg::S_IDLE;
      end
      default: begin
        state_d = rlpa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### hdl/rlpa_datapath.sv
module rlpa_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rlpa_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [rlpa_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  rlpa_pkg::in_t               in_i,
  input  rlpa_pkg::cmd_t              cmd_i,
  output rlpa_pkg::sts_t              sts_o,
  output logic                        result_valid_o,
  output rlpa_pkg::res_t              res_o
);

  // configuration
  logic [7:0]  num_ranges_q;
  logic [4:0]  num_lags_q;
  logic [10:0] sample_unit_q;
  logic [3:0]  range_stride_q;
  logic        xcf_mode_q;
  logic [13:0] xcf_offset_q;
  logic [7:0]  bad_range_q;
  logic [9:0]  start_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ranges_q   <= 8'd75;
      num_lags_q     <= 5'd18;
      sample_unit_q  <= 11'd10;
      range_stride_q <= 4'd2;
      xcf_mode_q     <= 1'b0;
      xcf_offset_q   <= '0;
      bad_range_q    <= 8'd128;
      start_delay_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rlpa_pkg::CFG_NUM_RANGES:   num_ranges_q   <= cfg_wdata_i[7:0];
        rlpa_pkg::CFG_NUM_LAGS:     num_lags_q     <= cfg_wdata_i[4:0];
        rlpa_pkg::CFG_SAMPLE_UNIT:  sample_unit_q  <= cfg_wdata_i[10:0];
        rlpa_pkg::CFG_RANGE_STRIDE: range_stride_q <= cfg_wdata_i[3:0];
        rlpa_pkg::CFG_XCF_MODE:     xcf_mode_q     <= cfg_wdata_i[0];
        rlpa_pkg::CFG_XCF_OFFSET:   xcf_offset_q   <= cfg_wdata_i[13:0];
        rlpa_pkg::CFG_BAD_RANGE:    bad_range_q    <= cfg_wdata_i[7:0];
        rlpa_pkg::CFG_START_DELAY:  start_delay_q  <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  rlpa_pkg::in_t run_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      run_q <= in_i;
    end
  end

  assign sts_o.nr = (num_ranges_q > 8'(rlpa_pkg::MAX_RANGES)) ?
                    8'(rlpa_pkg::MAX_RANGES) : num_ranges_q;
  assign sts_o.nl        = num_lags_q;
  assign sts_o.rec_zero  = (run_q.atten_recip == '0);
  assign sts_o.in_action = in_i.action;

  // lag table
  logic [15:0] lag_tab_q [rlpa_pkg::MAX_LAGS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && in_i.action == rlpa_pkg::ACT_LOAD_LAG) begin
      lag_tab_q[in_i.address[rlpa_pkg::LAG_AW-1:0]] <= {in_i.lag_second, in_i.lag_first};
    end
  end

  // sample positions
  logic [15:0] lag_e;
  logic [10:0] rsum;
  logic [14:0] base1;
  logic [13:0] p1_q, p2_q, p1_d, p2_d;

  always_comb begin
    if ({1'b0, cmd_i.rng} >= bad_range_q && cmd_i.lag == '0) begin
      lag_e = lag_tab_q[sts_o.nl];
    end else begin
      lag_e = lag_tab_q[cmd_i.lag];
    end
    rsum  = 11'(cmd_i.rng) + 11'(start_delay_q);
    base1 = 15'(rsum) * 15'(range_stride_q);
    p1_d  = 14'(19'(lag_e[7:0]) * 19'(sample_unit_q) + 19'(base1));
    p2_d  = 14'(19'(lag_e[15:8]) * 19'(sample_unit_q) + 19'(base1)
                + (xcf_mode_q ? 19'(xcf_offset_q) : 19'd0));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lag_step) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
  end

  // sample store
  logic [15:0] smem [rlpa_pkg::SAMPLE_DEPTH];
  logic [15:0] smp_rdata_q;
  logic [rlpa_pkg::SAMPLE_AW-1:0] smp_raddr;

  assign smp_raddr = (cmd_i.cnt[1] ? p2_q : p1_q)
                     + 14'(cmd_i.cnt[0] ? run_q.imag_offset : run_q.real_offset);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && in_i.action == rlpa_pkg::ACT_LOAD_SAMPLE) begin
      smem[in_i.address[rlpa_pkg::SAMPLE_AW-1:0]] <= in_i.sample_value;
    end
    if (cmd_i.rd_step) begin
      smp_rdata_q <= smem[smp_raddr];
    end
  end

  // dc removal: a1r, a1i, a2r, a2i
  logic signed [24:0] a_q [4];
  logic signed [24:0] a_new;
  logic signed [23:0] dc_sel;
  logic [1:0]         a_sel;

  assign a_sel = 2'(cmd_i.cnt - 3'd1);

  always_comb begin
    case (a_sel)
      2'd0:    dc_sel = run_q.dc_real_main;
      2'd1:    dc_sel = run_q.dc_imag_main;
      2'd2:    dc_sel = xcf_mode_q ? run_q.dc_real_second : run_q.dc_real_main;
      default: dc_sel = xcf_mode_q ? run_q.dc_imag_second : run_q.dc_imag_main;
    endcase
    a_new = $signed({smp_rdata_q[15], smp_rdata_q, 8'h00}) - $signed({dc_sel[23], dc_sel});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_step && cmd_i.cnt != 3'd0) begin
      a_q[a_sel] <= a_new;
    end
  end

  // complex product on one shared multiplier
  logic signed [24:0] mx, my;
  logic signed [49:0] prod_q;
  logic signed [52:0] re_q, im_q;

  always_comb begin
    case (cmd_i.cnt[1:0])
      2'd0:    begin mx = a_q[0]; my = a_q[2]; end
      2'd1:    begin mx = a_q[1]; my = a_q[3]; end
      2'd2:    begin mx = a_q[0]; my = a_q[3]; end
      default: begin mx = a_q[2]; my = a_q[1]; end
    endcase
  end

  // scaling by reciprocal
  logic signed [52:0] part;
  logic [52:0]        mag;
  logic [36:0]        sop;
  logic [53:0]        sp_q, hp_q, rounded;
  logic               neg_sel;
  logic signed [52:0] scaled;

  always_comb begin
    part    = cmd_i.cnt[1] ? im_q : re_q;
    mag     = part[52] ? 53'(-part) : 53'(part);
    sop     = cmd_i.cnt[0] ? 37'(mag[15:0]) : mag[52:16];
    rounded = hp_q + ((sp_q + 54'h8000) >> 16);
    neg_sel = (cmd_i.cnt == 3'd2) ? re_q[52] : im_q[52];
    scaled  = neg_sel ? 53'(-rounded) : 53'(rounded);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      prod_q <= mx * my;
      case (cmd_i.cnt)
        3'd1:    re_q <= 53'(prod_q);
        3'd2:    re_q <= re_q + 53'(prod_q);
        3'd3:    im_q <= 53'(prod_q);
        3'd4:    im_q <= im_q - 53'(prod_q);
        default: ;
      endcase
    end
    if (cmd_i.scl_step) begin
      sp_q <= 54'(sop) * 54'(run_q.atten_recip);
      case (cmd_i.cnt)
        3'd1, 3'd3: hp_q <= sp_q;
        3'd2:       re_q <= scaled;
        3'd4:       im_q <= scaled;
        default: ;
      endcase
    end
  end

  // accumulators
  logic [63:0] acc_re_mem [rlpa_pkg::ACC_DEPTH];
  logic [63:0] acc_im_mem [rlpa_pkg::ACC_DEPTH];
  logic [63:0] acc_re_rd_q, acc_im_rd_q;
  logic [rlpa_pkg::ACC_AW-1:0] acc_raddr;
  logic [63:0] sum_re, sum_im;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = b[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  assign acc_raddr = cmd_i.capture ? in_i.address[rlpa_pkg::ACC_AW-1:0] : cmd_i.idx;
  assign sum_re    = sat_add(acc_re_rd_q, 64'(re_q));
  assign sum_im    = sat_add(acc_im_rd_q, 64'(im_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we) begin
      acc_re_mem[cmd_i.clr_addr] <= '0;
      acc_im_mem[cmd_i.clr_addr] <= '0;
    end else if (cmd_i.acc_we) begin
      acc_re_mem[cmd_i.idx] <= sum_re;
      acc_im_mem[cmd_i.idx] <= sum_im;
    end
    if (cmd_i.acc_re) begin
      acc_re_rd_q <= acc_re_mem[acc_raddr];
      acc_im_rd_q <= acc_im_mem[acc_raddr];
    end
  end

  assign result_valid_o = cmd_i.res_valid;
  assign res_o.acf_real = cmd_i.res_read ? acc_re_rd_q : '0;
  assign res_o.acf_imag = cmd_i.res_read ? acc_im_rd_q : '0;
  assign res_o.done_res = cmd_i.res_run;

endmodule

### hdl/radar_lag_product_accumulator_core.sv
// load, unused and read items: S_DONE raises the result strobe; clear: S_CLEAR, then S_DONE
// run: each range/lag product steps S_LAG, S_RD, S_MUL, S_SCL, S_ACC, skipping S_SCL when
// the reciprocal is zero; one sample port read per cycle; complex product on one multiplier
// throughput: one item at a time; busy stays high until the result strobe has passed
// reset: registers take their reset values, then a clearing pass over every accumulator
// address holds busy high; results cannot be stalled by the receiver
module radar_lag_product_accumulator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  rlpa_pkg::in_t               in_i,
  input  logic                        cfg_we_i,
  input  logic [rlpa_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [rlpa_pkg::CFG_DW-1:0] cfg_wdata_i,
  output logic                        result_valid_o,
  output rlpa_pkg::res_t              res_o
);

  rlpa_pkg::cmd_t cmd;
  rlpa_pkg::sts_t sts;

  rlpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  rlpa_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_i           (in_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

endmodule

### hdl/rlpa_checker.sv
`include "radar_lag_product_accumulator_core_defines.svh"

module rlpa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           result_valid_o,
  input rlpa_pkg::res_t res_o
);

  `RLPA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `RLPA_ASSERT_IMPLY(a_result_in_busy, clk_i, rst_ni, result_valid_o, busy)
  `RLPA_ASSERT_NEXT(a_result_single, clk_i, rst_ni, result_valid_o, !result_valid_o)
  `RLPA_ASSERT_IMPLY(a_run_no_data, clk_i, rst_ni, result_valid_o && res_o.done_res,
    res_o.acf_real == '0 && res_o.acf_imag == '0)

endmodule

bind radar_lag_product_accumulator_core rlpa_checker u_rlpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .res_o          (res_o)
);
